>>> src/dcpr_pkg.sv
// dcpr_pkg: shared types and constants of the captive portal dns responder
`default_nettype none

package dcpr_pkg;

    // stream field widths
    localparam int LEN_W     = 10;
    localparam int TDATA_W   = 24;
    localparam int TUSER_W   = 2;

    // command carried in the slave tuser
    localparam logic CMD_RX   = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // verdict carried in the master tuser
    localparam logic [1:0] V_BYTE  = 2'd0;
    localparam logic [1:0] V_READY = 2'd1;
    localparam logic [1:0] V_DROP  = 2'd2;

    // query parse phases
    localparam logic [2:0] PH_HEADER     = 3'd0;
    localparam logic [2:0] PH_LABEL_LEN  = 3'd1;
    localparam logic [2:0] PH_LABEL_BODY = 3'd2;
    localparam logic [2:0] PH_POINTER    = 3'd3;
    localparam logic [2:0] PH_QFIELDS    = 3'd4;
    localparam logic [2:0] PH_DONE       = 3'd5;

    // pending reply kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_ECHO   = 2'd1;
    localparam logic [1:0] KIND_ANSWER = 2'd2;

    // dns header and answer constants
    localparam int         HDR_BYTES   = 12;
    localparam int         ANS_BYTES   = 16;
    localparam logic [7:0] OPCODE_MASK = 8'h78;
    localparam logic [7:0] FLAGS_KEEP  = 8'h7F;
    localparam logic [7:0] FLAGS_SET   = 8'h84;
    localparam logic [7:0] PTR_MARK    = 8'hC0;
    localparam logic [7:0] NAME_OFFSET = 8'd12;
    localparam logic [7:0] TYPE_A_LO   = 8'd1;
    localparam logic [7:0] CLASS_TTL   = 8'd30;
    localparam logic [7:0] RDLEN_IPV4  = 8'd4;
    localparam logic [15:0] TYPE_A     = 16'd1;
    localparam logic [31:0] IPV4_RESET = 32'hC0A80401;

    // one accepted transaction after decode, waiting for the store read
    typedef struct packed {
        logic             has_result;
        logic [1:0]       verdict;
        logic [LEN_W-1:0] length;
        logic [7:0]       tx_const;
        logic             use_mem;
        logic             tx_last;
    } stage_t;

endpackage

`default_nettype wire

>>> src/dcpr_store.sv
// dcpr_store: packet byte store with one write port and a registered read port
`default_nettype none

module dcpr_store
    import dcpr_pkg::*;
#(
    parameter int  BUFFER_BYTES = 512,
    localparam int ADDR_W       = $clog2(BUFFER_BYTES)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [7:0]        rd_data
);

    logic [7:0] mem [BUFFER_BYTES];
    logic [7:0] rd_data_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/dcpr_ctrl.sv
// dcpr_ctrl: query parser, verdict logic and reply byte sequencer
`default_nettype none

module dcpr_ctrl
    import dcpr_pkg::*;
#(
    parameter int  BUFFER_BYTES = 512,
    localparam int ADDR_W       = $clog2(BUFFER_BYTES)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              cmd,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              rx_last,
    input  wire logic [31:0]       answer_ipv4,
    output stage_t                 item,
    output logic                   wr_en,
    output logic [ADDR_W-1:0]      wr_addr,
    output logic [ADDR_W-1:0]      rd_addr
);

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [2:0]        phase_reg, phase_next;
    logic [7:0]        label_reg, label_next;
    logic              hr_reg, hr_next;
    logic [15:0]       qtype_reg, qtype_next;
    logic [15:0]       qclass_reg, qclass_next;
    logic [7:0]        flags_reg, flags_next;
    logic [7:0]        qd_hi_reg, qd_hi_next;
    logic [1:0]        kind_reg, kind_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  read_pos_reg, read_pos_next;

    logic                   stored;
    logic                   drop;
    logic [CNT_W:0]         len_plus;
    logic [CNT_W-1:0]       qlen;
    logic [CNT_W:0]         pos_inc;
    logic [CNT_W-1:0]       off_full;
    logic [CNT_W+LEN_W-1:0] tot_ext;

    assign stored  = count_reg < CNT_W'(BUFFER_BYTES);
    assign wr_addr = count_reg[ADDR_W-1:0];
    assign rd_addr = read_pos_reg[ADDR_W-1:0];

    // next state and decoded transaction
    always_comb
    begin
        count_next    = count_reg;
        phase_next    = phase_reg;
        label_next    = label_reg;
        hr_next       = hr_reg;
        qtype_next    = qtype_reg;
        qclass_next   = qclass_reg;
        flags_next    = flags_reg;
        qd_hi_next    = qd_hi_reg;
        kind_next     = kind_reg;
        total_next    = total_reg;
        read_pos_next = read_pos_reg;
        item          = '0;
        wr_en         = 1'b0;
        drop          = 1'b0;
        len_plus      = '0;
        tot_ext       = '0;
        qlen          = total_reg;
        pos_inc       = {1'b0, read_pos_reg} + (CNT_W+1)'(1);
        off_full      = '0;

        if (accept && cmd == CMD_RX)
        begin
            kind_next = KIND_NONE;
            // store and parse while there is room
            if (stored)
            begin
                wr_en      = 1'b1;
                count_next = count_reg + CNT_W'(1);
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (count_reg == CNT_W'(2))
                        begin
                            flags_next = rx_byte;
                            if ((rx_byte & OPCODE_MASK) != 8'h00)
                            begin
                                hr_next = 1'b1;
                            end
                        end
                        if (count_reg == CNT_W'(4))
                        begin
                            qd_hi_next = rx_byte;
                        end
                        if (count_reg == CNT_W'(5) && qd_hi_reg == 8'h00 && rx_byte == 8'h00)
                        begin
                            hr_next = 1'b1;
                        end
                        if (count_reg == CNT_W'(HDR_BYTES - 1))
                        begin
                            phase_next = PH_LABEL_LEN;
                        end
                    end
                    PH_LABEL_LEN:
                    begin
                        if (rx_byte == 8'h00)
                        begin
                            phase_next = PH_QFIELDS;
                            label_next = 8'h00;
                        end
                        else if ((rx_byte & PTR_MARK) == PTR_MARK)
                        begin
                            phase_next = PH_POINTER;
                        end
                        else
                        begin
                            label_next = rx_byte;
                            phase_next = PH_LABEL_BODY;
                        end
                    end
                    PH_LABEL_BODY:
                    begin
                        label_next = label_reg - 8'd1;
                        if (label_next == 8'h00)
                        begin
                            phase_next = PH_LABEL_LEN;
                        end
                    end
                    PH_POINTER:
                    begin
                        phase_next = PH_QFIELDS;
                        label_next = 8'h00;
                    end
                    PH_QFIELDS:
                    begin
                        if (label_reg == 8'd0)
                        begin
                            qtype_next = {rx_byte, 8'h00};
                        end
                        else if (label_reg == 8'd1)
                        begin
                            qtype_next = {qtype_reg[15:8], rx_byte};
                        end
                        else if (label_reg == 8'd2)
                        begin
                            qclass_next = {rx_byte, 8'h00};
                        end
                        else
                        begin
                            qclass_next = {qclass_reg[15:8], rx_byte};
                            phase_next  = PH_DONE;
                        end
                        label_next = label_reg + 8'd1;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // verdict on the final byte
            if (rx_last)
            begin
                drop     = (count_next < CNT_W'(HDR_BYTES)) || hr_next
                           || (phase_next != PH_DONE);
                len_plus = {1'b0, count_next} + (CNT_W+1)'(ANS_BYTES);
                if (!drop && qtype_next == TYPE_A)
                begin
                    if (len_plus > (CNT_W+1)'(BUFFER_BYTES))
                    begin
                        drop = 1'b1;
                    end
                    else
                    begin
                        kind_next  = KIND_ANSWER;
                        total_next = len_plus[CNT_W-1:0];
                    end
                end
                else if (!drop)
                begin
                    kind_next  = KIND_ECHO;
                    total_next = count_next;
                end
                tot_ext         = (CNT_W+LEN_W)'(total_next);
                item.has_result = 1'b1;
                item.verdict    = drop ? V_DROP : V_READY;
                item.length     = drop ? '0 : tot_ext[LEN_W-1:0];
                read_pos_next   = '0;
                count_next      = '0;
                phase_next      = PH_HEADER;
                label_next      = 8'h00;
                hr_next         = 1'b0;
                if (drop)
                begin
                    kind_next  = KIND_NONE;
                    total_next = '0;
                end
            end
        end
        else if (accept && kind_reg != KIND_NONE && read_pos_reg < total_reg)
        begin
            // one reply byte
            item.has_result = 1'b1;
            item.verdict    = V_BYTE;
            qlen            = (kind_reg == KIND_ANSWER) ? total_reg - CNT_W'(ANS_BYTES)
                                                        : total_reg;
            off_full        = read_pos_reg - qlen;
            if (read_pos_reg < qlen)
            begin
                if (read_pos_reg == CNT_W'(2))
                begin
                    item.tx_const = (flags_reg & FLAGS_KEEP) | FLAGS_SET;
                end
                else if (read_pos_reg >= CNT_W'(6) && read_pos_reg <= CNT_W'(HDR_BYTES - 1))
                begin
                    // counts zeroed, ancount low byte one for an answer
                    item.tx_const = (read_pos_reg == CNT_W'(7) && kind_reg == KIND_ANSWER)
                                    ? 8'd1 : 8'd0;
                end
                else
                begin
                    item.use_mem = 1'b1;
                end
            end
            else
            begin
                // appended answer record
                case (off_full[3:0])
                    4'd0:    item.tx_const = PTR_MARK;
                    4'd1:    item.tx_const = NAME_OFFSET;
                    4'd3:    item.tx_const = TYPE_A_LO;
                    4'd4:    item.tx_const = qclass_reg[15:8];
                    4'd5:    item.tx_const = qclass_reg[7:0];
                    4'd9:    item.tx_const = CLASS_TTL;
                    4'd11:   item.tx_const = RDLEN_IPV4;
                    4'd12:   item.tx_const = answer_ipv4[31:24];
                    4'd13:   item.tx_const = answer_ipv4[23:16];
                    4'd14:   item.tx_const = answer_ipv4[15:8];
                    4'd15:   item.tx_const = answer_ipv4[7:0];
                    default: item.tx_const = 8'h00;
                endcase
            end
            item.tx_last  = (pos_inc == {1'b0, total_reg});
            read_pos_next = pos_inc[CNT_W-1:0];
            if (pos_inc >= {1'b0, total_reg})
            begin
                kind_next     = KIND_NONE;
                total_next    = '0;
                read_pos_next = '0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            phase_reg    <= PH_HEADER;
            label_reg    <= 8'h00;
            hr_reg       <= 1'b0;
            qtype_reg    <= 16'h0000;
            qclass_reg   <= 16'h0000;
            kind_reg     <= KIND_NONE;
            total_reg    <= '0;
            read_pos_reg <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            phase_reg    <= phase_next;
            label_reg    <= label_next;
            hr_reg       <= hr_next;
            qtype_reg    <= qtype_next;
            qclass_reg   <= qclass_next;
            kind_reg     <= kind_next;
            total_reg    <= total_next;
            read_pos_reg <= read_pos_next;
        end
    end

    // captured header bytes
    always_ff @(posedge clk)
    begin
        flags_reg <= flags_next;
        qd_hi_reg <= qd_hi_next;
    end

`ifndef NO_ASSERTIONS
    // a pending reply always has bytes left to send
    assert property (@(posedge clk) disable iff (!rst_n)
        kind_reg != KIND_NONE |-> read_pos_reg < total_reg)
        else $error("reply pending with no bytes left");

    // the byte count never passes the store size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(BUFFER_BYTES))
        else $error("byte count beyond store size");
`endif

endmodule

`default_nettype wire

>>> src/dns_captive_portal_responder.sv
// dns_captive_portal_responder: top level with stream handshake and result register
//
// Slave stream: one transaction per query byte or read request. tuser[0] is the
// command (0 receive a query byte, 1 read the next reply byte), tdata[7:0] the
// query byte and tlast marks the final byte of the query datagram.
// Master stream: at most one transaction per accepted input. tuser[1:0] is the
// verdict (0 reply byte, 1 reply ready, 2 query dropped), tdata[9:0] the reply
// length, tdata[17:10] the reply byte, tlast the final reply byte.
// An accepted input loads the input stage together with the registered packet
// store read; the result register then loads from the input stage whenever it is
// empty or its result is taken. Throughput is one transaction per cycle while the
// receiver does not stall; non-last query bytes and reads with no reply pending
// give no result.
// The input stage and the result register are separate, so one more input is
// taken while a result waits on a stalled receiver; then tready drops.
// Reset clears the parser, any pending reply and restores the answer address
// to 192.168.4.1. The store needs no clearing pass.
// cfg_we writes cfg_data as the answer address; write it only while idle.
`default_nettype none

module dns_captive_portal_responder
    import dcpr_pkg::*;
#(
    parameter int  BUFFER_BYTES = 512,
    localparam int ADDR_W       = $clog2(BUFFER_BYTES)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_data,
    // slave stream
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,  // [7:0] rx_byte
    input  wire logic [0:0]         s_axis_tuser,  // [0] cmd
    input  wire logic               s_axis_tlast,
    // master stream
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,  // [9:0] reply_length, [17:10] tx_byte
    output logic [TUSER_W-1:0]      m_axis_tuser,  // [1:0] verdict
    output logic                    m_axis_tlast
);

    logic [31:0]      ipv4_reg;
    logic             s1_valid_reg;
    stage_t           s1_item_reg;
    stage_t           item;
    logic             m_valid_reg;
    logic [1:0]       m_verdict_reg;
    logic [LEN_W-1:0] m_length_reg;
    logic [7:0]       m_tx_reg;
    logic             m_last_reg;

    logic              s_accept;
    logic              s1_adv;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // handshake
    assign s1_adv        = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // answer address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipv4_reg <= IPV4_RESET;
        end
        else if (cfg_we)
        begin
            ipv4_reg <= cfg_data;
        end
    end

    dcpr_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (s_accept),
        .cmd         (s_axis_tuser[0]),
        .rx_byte     (s_axis_tdata),
        .rx_last     (s_axis_tlast),
        .answer_ipv4 (ipv4_reg),
        .item        (item),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .rd_addr     (rd_addr)
    );

    dcpr_store #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_axis_tdata),
        .rd_en   (s_accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_item_reg <= item;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            m_valid_reg <= s1_valid_reg && s1_item_reg.has_result;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            m_verdict_reg <= s1_item_reg.verdict;
            m_length_reg  <= s1_item_reg.length;
            m_tx_reg      <= s1_item_reg.use_mem ? rd_data : s1_item_reg.tx_const;
            m_last_reg    <= s1_item_reg.tx_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_verdict_reg;
    assign m_axis_tdata  = {(TDATA_W - LEN_W - 8)'(0), m_tx_reg, m_length_reg};
    assign m_axis_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    // no new transaction enters while both stages are held by a stalled receiver
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && m_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while both stages full");

    // the last marker only travels with a reply byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == V_BYTE)
        else $error("tlast on a verdict transaction");

    // a reply byte carries no length and a drop carries no length
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == V_BYTE || m_axis_tuser == V_DROP)
        |-> m_axis_tdata[LEN_W-1:0] == '0)
        else $error("length set outside a reply ready verdict");

    // a verdict transaction carries no reply byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != V_BYTE |-> m_axis_tdata[LEN_W+7:LEN_W] == 8'h00)
        else $error("reply byte set on a verdict");
`endif

endmodule

`default_nettype wire

>>> test/tb_dns_captive_portal_responder.sv
// testbench for the captive portal dns responder: directed and random query streams checked against a predictor
`timescale 1ns / 1ps

import dcpr_pkg::*;

class dns_reply_scoreboard #(int STORE_BYTES = 512);

    typedef struct packed {
        logic [1:0]       verdict;
        logic [LEN_W-1:0] length;
        logic [7:0]       tx_byte;
        logic             tx_last;
    } result_t;

    result_t     expected_results[$];
    int          errors;

    // predicted block state
    bit [31:0]   answer_addr;
    bit [7:0]    query_bytes[STORE_BYTES];
    int unsigned stored_count;
    bit [2:0]    phase;
    bit [7:0]    label_left;
    bit          header_bad;
    bit [15:0]   q_type;
    bit [15:0]   q_class;
    bit [1:0]    reply_kind;
    int unsigned reply_total;
    int unsigned read_pos;

    function new();
        errors       = 0;
        answer_addr  = IPV4_RESET;
        stored_count = 0;
        phase        = PH_HEADER;
        label_left   = 8'd0;
        header_bad   = 1'b0;
        q_type       = 16'd0;
        q_class      = 16'd0;
        reply_kind   = KIND_NONE;
        reply_total  = 0;
        read_pos     = 0;
    endfunction

    function void set_answer_addr(bit [31:0] addr);
        answer_addr = addr;
    endfunction

    function int outstanding();
        return expected_results.size();
    endfunction

    function int pending_bytes();
        return (reply_kind == KIND_NONE) ? 0 : int'(reply_total - read_pos);
    endfunction

    // walk header, name labels and question fields as the bytes arrive
    function void parse_query_byte(int unsigned pos, bit [7:0] b);
        case (phase)
            PH_HEADER:
            begin
                // flags high byte carries the opcode, bytes 4 and 5 the question count
                if (pos == 2 && (b & OPCODE_MASK) != 8'd0) header_bad = 1'b1;
                if (pos == 5 && query_bytes[4] == 8'd0 && b == 8'd0) header_bad = 1'b1;
                if (pos == HDR_BYTES - 1) phase = PH_LABEL_LEN;
            end
            PH_LABEL_LEN:
            begin
                if (b == 8'd0)
                begin
                    phase      = PH_QFIELDS;
                    label_left = 8'd0;
                end
                else if ((b & PTR_MARK) == PTR_MARK)
                    phase = PH_POINTER;
                else
                begin
                    label_left = b;
                    phase      = PH_LABEL_BODY;
                end
            end
            PH_LABEL_BODY:
            begin
                label_left = label_left - 8'd1;
                if (label_left == 8'd0) phase = PH_LABEL_LEN;
            end
            PH_POINTER:
            begin
                phase      = PH_QFIELDS;
                label_left = 8'd0;
            end
            PH_QFIELDS:
            begin
                // label_left counts the question type and class bytes here
                case (label_left)
                    8'd0: q_type[15:8] = b;
                    8'd1: q_type[7:0] = b;
                    8'd2: q_class[15:8] = b;
                    default:
                    begin
                        q_class[7:0] = b;
                        phase        = PH_DONE;
                    end
                endcase
                label_left = label_left + 8'd1;
            end
            default:
            begin
            end
        endcase
    endfunction

    // one byte of the reply: echoed query, then the appended answer record
    function bit [7:0] reply_octet(int unsigned p);
        int unsigned qlen;
        qlen = (reply_kind == KIND_ANSWER) ? reply_total - ANS_BYTES : reply_total;
        if (p < qlen)
        begin
            if (p == 2) return (query_bytes[2] & FLAGS_KEEP) | FLAGS_SET;
            if (p >= 6 && p <= 11) return (p == 7 && reply_kind == KIND_ANSWER) ? 8'd1 : 8'd0;
            return query_bytes[p];
        end
        case (p - qlen)
            0:       return PTR_MARK;
            1:       return NAME_OFFSET;
            3:       return TYPE_A_LO;
            4:       return q_class[15:8];
            5:       return q_class[7:0];
            9:       return CLASS_TTL;
            11:      return RDLEN_IPV4;
            12:      return answer_addr[31:24];
            13:      return answer_addr[23:16];
            14:      return answer_addr[15:8];
            15:      return answer_addr[7:0];
            default: return 8'd0;
        endcase
    endfunction

    // accepted input transaction: update state, queue the result it causes
    function void note_request(logic cmd, logic [7:0] b, logic last);
        int unsigned len;
        bit          drop;
        result_t     r;

        if (cmd == CMD_RX)
        begin
            reply_kind = KIND_NONE;
            if (stored_count < STORE_BYTES)
            begin
                query_bytes[stored_count] = b;
                parse_query_byte(stored_count, b);
                stored_count++;
            end
            if (!last)
                return;
            len  = stored_count;
            drop = (len < HDR_BYTES) || header_bad || (phase != PH_DONE);
            if (!drop && q_type == TYPE_A)
            begin
                if (len + ANS_BYTES > STORE_BYTES)
                    drop = 1'b1;
                else
                begin
                    reply_kind  = KIND_ANSWER;
                    reply_total = len + ANS_BYTES;
                end
            end
            else if (!drop)
            begin
                reply_kind  = KIND_ECHO;
                reply_total = len;
            end
            read_pos   = 0;
            r.verdict  = drop ? V_DROP : V_READY;
            r.length   = drop ? '0 : LEN_W'(reply_total);
            r.tx_byte  = 8'd0;
            r.tx_last  = 1'b0;
            expected_results.push_back(r);
            stored_count = 0;
            phase        = PH_HEADER;
            label_left   = 8'd0;
            header_bad   = 1'b0;
            if (drop)
            begin
                reply_kind  = KIND_NONE;
                reply_total = 0;
            end
            return;
        end

        // read request: ignored unless a reply is pending
        if (reply_kind == KIND_NONE || read_pos >= reply_total)
            return;
        r.verdict = V_BYTE;
        r.length  = '0;
        r.tx_byte = reply_octet(read_pos);
        r.tx_last = (read_pos + 1 == reply_total);
        expected_results.push_back(r);
        read_pos++;
        if (read_pos >= reply_total)
        begin
            reply_kind  = KIND_NONE;
            reply_total = 0;
            read_pos    = 0;
        end
    endfunction

    // output transaction against the oldest expectation
    function void check_result(logic [1:0] verdict, logic [LEN_W-1:0] length,
                               logic [7:0] tx_byte, logic tx_last);
        result_t want;
        if (expected_results.size() == 0)
        begin
            $error("result with nothing expected: verdict %0d length %0d byte %02h last %0b",
                   verdict, length, tx_byte, tx_last);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        if (verdict !== want.verdict)
        begin
            $error("verdict: expected %0d, got %0d", want.verdict, verdict);
            errors++;
        end
        if (length !== want.length)
        begin
            $error("reply_length: expected %0d, got %0d", want.length, length);
            errors++;
        end
        if (tx_byte !== want.tx_byte)
        begin
            $error("tx_byte: expected %02h, got %02h", want.tx_byte, tx_byte);
            errors++;
        end
        if (tx_last !== want.tx_last)
        begin
            $error("tx_last: expected %0b, got %0b", want.tx_last, tx_last);
            errors++;
        end
    endfunction

endclass

module tb_dns_captive_portal_responder;

    localparam int BUF_BYTES   = 512;
    localparam int PHASE_ITEMS = 100;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_we        = 1'b0;
    logic [31:0]        cfg_data      = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = '0;  // [7:0] rx_byte
    logic [0:0]         s_axis_tuser  = '0;  // [0] cmd
    logic               s_axis_tlast  = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;        // [9:0] reply_length, [17:10] tx_byte
    logic [TUSER_W-1:0] m_axis_tuser;        // [1:0] verdict
    logic               m_axis_tlast;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_len     = 0;
    int n_offered    = 0;
    int n_taken      = 0;

    bit [7:0] pkt[$];

    dns_reply_scoreboard #(BUF_BYTES) sb = new;

    dns_captive_portal_responder #(
        .BUFFER_BYTES (BUF_BYTES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // run guard
    initial
    begin
        #(10_000_000);
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random stalls, or a long hold-off while hold_len counts down
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_len--;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // monitor: check output transactions, then note the accepted input one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata[LEN_W-1:0],
                                m_axis_tdata[LEN_W+7:LEN_W], m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_request(s_axis_tuser[0], s_axis_tdata, s_axis_tlast);
                n_taken++;
            end
        end
    end

    // offer one input transaction, with random idle cycles first
    task automatic offer(input logic cmd, input logic [7:0] data, input logic last);
        int goal;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        goal = n_taken + 1;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        n_offered++;
        wait (n_taken == goal);
    endtask

    function automatic void add8(bit [7:0] b);
        pkt.push_back(b);
    endfunction

    function automatic void add16(bit [15:0] w);
        pkt.push_back(w[15:8]);
        pkt.push_back(w[7:0]);
    endfunction

    // header: random id, given flags and question count, other counts all fill
    function automatic void begin_query(bit [15:0] flags, bit [15:0] qdcount, bit [7:0] fill);
        pkt.delete();
        add16(16'($urandom));
        add16(flags);
        add16(qdcount);
        repeat (6) add8(fill);
    endfunction

    function automatic void add_label(bit [7:0] len);
        add8(len);
        repeat (len) add8(8'($urandom));
    endfunction

    task automatic send_query();
        for (int i = 0; i < pkt.size(); i++)
            offer(CMD_RX, pkt[i], i == pkt.size() - 1);
    endtask

    task automatic read_reply(input int n);
        repeat (n) offer(CMD_READ, 8'($urandom), 1'($urandom));
    endtask

    // read all, part or none of whatever reply is pending, sometimes with stray reads past its end or with none pending
    task automatic read_some();
        int pending;
        int roll;
        pending = sb.pending_bytes();
        roll    = $urandom_range(0, 99);
        if (pending == 0)
        begin
            if (roll < 30) read_reply($urandom_range(1, 2));
        end
        else if (roll < 70)
            read_reply(pending + $urandom_range(0, 2));
        else if (roll < 85)
            read_reply($urandom_range(1, pending));
    endtask

    // mostly well-formed queries with random content, some malformed or cut short
    task automatic random_query();
        bit [15:0] flags;
        bit [15:0] qdcount;
        bit        ended;
        int        roll;

        flags = 16'($urandom);
        if ($urandom_range(0, 99) < 10)
        begin
            if (flags[14:11] == 4'd0) flags[11] = 1'b1;
        end
        else
            flags[14:11] = 4'd0;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            qdcount = 16'h0000;
        else if (roll < 14)
            qdcount = 16'h0100;
        else if (roll < 55)
            qdcount = 16'h0001;
        else
            qdcount = 16'($urandom_range(1, 65535));
        begin_query(flags, qdcount, 8'($urandom));

        // name: short labels, rarely a long one, sometimes ended by a pointer
        ended = 1'b0;
        for (int n = $urandom_range(0, 3); n > 0 && !ended; n--)
        begin
            roll = $urandom_range(0, 99);
            if (roll == 0)
                add_label(8'h80);
            else if (roll < 3)
                add_label(8'h40 | 8'($urandom_range(0, 3)));
            else if (roll < 12)
            begin
                add8(PTR_MARK | 8'($urandom_range(0, 63)));
                add8(8'($urandom));
                ended = 1'b1;
            end
            else
                add_label(8'($urandom_range(1, 8)));
        end
        if (!ended) add8(8'h00);

        add16(($urandom_range(0, 99) < 60) ? TYPE_A : 16'($urandom));
        add16($urandom_range(0, 1) ? 16'h0001 : 16'($urandom));
        if ($urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 12)) add8(8'($urandom));

        // truncated datagram
        if ($urandom_range(0, 99) < 12)
        begin
            roll = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > roll) void'(pkt.pop_back());
        end
        send_query();
        read_some();
    endtask

    task automatic directed_checks();
        // read with no reply pending
        offer(CMD_READ, 8'hFF, 1'b1);

        // runt datagram of eleven bytes
        begin_query(16'h0100, 16'h0001, 8'h00);
        void'(pkt.pop_back());
        send_query();

        // minimal a query with the reset address, counts all ones to be zeroed
        begin_query(16'h0100, 16'h0001, 8'hFF);
        add_label(8'd1);
        add8(8'h00);
        add16(TYPE_A);
        add16(16'h0001);
        send_query();
        read_reply(sb.pending_bytes() + 1);

        // pointer name, non-a type: echo only, cancelled part-way by a new query
        begin_query(16'h87FF, 16'h0001, 8'hA5);
        add8(8'hC0);
        add8(8'h0C);
        add16(16'h001C);
        add16(16'hFF01);
        send_query();
        read_reply(5);

        // nonzero opcode
        begin_query(16'h7800, 16'h0001, 8'h00);
        add8(8'h00);
        add16(TYPE_A);
        add16(16'h0001);
        send_query();
        read_reply(1);

        // zero question count
        begin_query(16'h0100, 16'h0000, 8'h00);
        add8(8'h00);
        add16(TYPE_A);
        add16(16'h0001);
        send_query();

        // length byte with top bits 01 read as an ordinary length
        begin_query(16'h0100, 16'h0001, 8'h00);
        add_label(8'h41);
        add8(8'h00);
        add16(TYPE_A);
        add16(16'hFFFF);
        send_query();
        read_reply(sb.pending_bytes());

        // question class cut off
        begin_query(16'h0100, 16'h0001, 8'h00);
        add8(8'h00);
        add16(TYPE_A);
        add8(8'h00);
        send_query();

        // name cut off inside a label
        begin_query(16'h0100, 16'h0001, 8'h00);
        add_label(8'd5);
        void'(pkt.pop_back());
        send_query();
    endtask

    // buffer limits: oversized datagram, then a answers that just fit and just miss
    task automatic large_datagrams();
        begin_query(16'h0100, 16'h0001, 8'h00);
        add8(8'h00);
        add16(16'h0010);
        add16(16'h0001);
        while (pkt.size() < BUF_BYTES + 4) add8(8'($urandom));
        send_query();
        // long receiver hold-off while reads keep coming, so the block backs up
        hold_len = 400;
        read_reply(16);

        for (int extra = 0; extra < 2; extra++)
        begin
            begin_query(16'h0100, 16'h0001, 8'h00);
            add8(8'h00);
            add16(TYPE_A);
            add16(16'($urandom));
            while (pkt.size() < BUF_BYTES - ANS_BYTES + extra) add8(8'($urandom));
            send_query();
            read_reply(16);
        end
    endtask

    // cancel any pending reply, drain results, let the pipeline empty
    task automatic close_phase();
        offer(CMD_RX, 8'($urandom), 1'b1);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_answer_addr(input logic [31:0] addr);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= addr;
        sb.set_answer_addr(addr);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int tx_pct, input int rx_pct);
        int start;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        start        = n_offered;
        while (n_offered - start < PHASE_ITEMS) random_query();
        close_phase();
    endtask

    // stimulus
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_checks();
        close_phase();

        set_answer_addr(32'h0000_0000);
        large_datagrams();
        random_phase(0, 0);

        set_answer_addr(32'hFFFF_FFFF);
        random_phase(52, 0);

        set_answer_addr(32'($urandom));
        random_phase(0, 52);

        set_answer_addr(32'h8000_0001);
        random_phase(20, 20);

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
src/dcpr_pkg.sv
src/dcpr_store.sv
src/dcpr_ctrl.sv
src/dns_captive_portal_responder.sv
test/tb_dns_captive_portal_responder.sv
